[hw/rtl/u2r_pkg.sv]
`default_nettype none

package u2r_pkg;

   // one macropixel in, two rgb565 pixels out
   typedef struct packed {
      logic [7:0] chroma_u;
      logic [7:0] luma_even;
      logic [7:0] chroma_v;
      logic [7:0] luma_odd;
      logic       line_last_in;
   } req_word_type;

   typedef struct packed {
      logic [15:0] first_pixel;
      logic [15:0] second_pixel;
      logic        line_last_out;
   } rsp_word_type;

   // chroma products shared by both pixels of a word
   typedef struct packed {
      logic [15:0] red_v;    // 204v + (v >> 1)
      logic [15:0] green_uv; // 104v + 50u
      logic [15:0] blue_u;   // 258u
   } chroma_terms_type;

   localparam logic [7:0] LEVEL_OFFSET = 8'd16;
   localparam logic [7:0] CHROMA_MAX   = 8'd240;
   localparam logic [7:0] LUMA_MAX     = 8'd235;

   localparam logic [7:0] Y_GAIN  = 8'd149;
   localparam logic [7:0] RV_GAIN = 8'd204;
   localparam logic [7:0] GV_GAIN = 8'd104;
   localparam logic [7:0] GU_GAIN = 8'd50;
   localparam logic [8:0] BU_GAIN = 9'd258;

   localparam int SUM_W = 18;
   localparam logic signed [SUM_W-1:0] R_BIAS = 18'sd22840;
   localparam logic signed [SUM_W-1:0] G_BIAS = 18'sd17312;
   localparam logic signed [SUM_W-1:0] B_BIAS = 18'sd28832;

   // clamp to 16..hi, then remove the 16 offset
   function automatic logic [7:0] clamp_off(input logic [7:0] x, input logic [7:0] hi);
      logic [7:0] c;
      begin
         c = x;
         if (c < LEVEL_OFFSET) begin
            c = LEVEL_OFFSET;
         end
         if (c > hi) begin
            c = hi;
         end
         return c - LEVEL_OFFSET;
      end
   endfunction

   // floor divide by 128, limited to 0..255
   function automatic logic [7:0] sat8(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-8:0] q;
      begin
         q = s[SUM_W-1:7];
         if (q < 0) begin
            return 8'd0;
         end else if (q > 11'sd255) begin
            return 8'd255;
         end else begin
            return q[7:0];
         end
      end
   endfunction

   function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

`default_nettype wire

[hw/rtl/uyvy_to_rgb565_converter.sv]
`default_nettype none
// a req word passes stage 1, stage 2, stage 3 and the output register in turn before rsp_valid rises
// throughput: one macropixel word per clock while rsp is not stalled, set by the four-stage pipeline
// a stall on rsp freezes every stage at once, so req_stall follows a held rsp word
// reset (synchronous, active high) clears only the stage valid bits; data is not reset

module uyvy_to_rgb565_converter (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire u2r_pkg::req_word_type  req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output u2r_pkg::rsp_word_type       rsp_word
);
   import u2r_pkg::*;

   // pipeline advance: everything moves unless a finished word is held
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // stage 1: clamp and remove offsets
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_u_ff, s1_v_ff, s1_y0_ff, s1_y1_ff;
   logic       s1_last_ff;

   // stage 2: products
   logic             s2_valid_ff;
   logic [15:0]      s2_luma0_ff, s2_luma1_ff;
   logic [15:0]      s2_luma0_in, s2_luma1_in;
   chroma_terms_type s2_chroma_ff, s2_chroma_in;
   logic             s2_last_ff;

   // stage 3: channel sums, held inside the pixel units
   logic        s3_valid_ff;
   logic        s3_last_ff;
   logic [15:0] pixel0, pixel1;

   // stage 4: output register
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   assign s1_valid_in = req_valid && !req_stall;

   always_comb begin
      s2_luma0_in           = 16'(s1_y0_ff * Y_GAIN);
      s2_luma1_in           = 16'(s1_y1_ff * Y_GAIN);
      s2_chroma_in.red_v    = 16'(s1_v_ff * RV_GAIN) + 16'(s1_v_ff >> 1);
      s2_chroma_in.green_uv = 16'(s1_v_ff * GV_GAIN) + 16'(s1_u_ff * GU_GAIN);
      s2_chroma_in.blue_u   = 16'(s1_u_ff * BU_GAIN);
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_u_ff      <= clamp_off(req_word.chroma_u,  CHROMA_MAX);
         s1_v_ff      <= clamp_off(req_word.chroma_v,  CHROMA_MAX);
         s1_y0_ff     <= clamp_off(req_word.luma_even, LUMA_MAX);
         s1_y1_ff     <= clamp_off(req_word.luma_odd,  LUMA_MAX);
         s1_last_ff   <= req_word.line_last_in;

         s2_luma0_ff  <= s2_luma0_in;
         s2_luma1_ff  <= s2_luma1_in;
         s2_chroma_ff <= s2_chroma_in;
         s2_last_ff   <= s1_last_ff;

         s3_last_ff   <= s2_last_ff;

         rsp_word_ff.first_pixel   <= pixel0;
         rsp_word_ff.second_pixel  <= pixel1;
         rsp_word_ff.line_last_out <= s3_last_ff;
      end
   end

   // even pixel
   u2r_pixel u_pixel_even (
      .clock     (clock),
      .enable    (advance),
      .luma_term (s2_luma0_ff),
      .chroma    (s2_chroma_ff),
      .pixel     (pixel0)
   );

   // odd pixel, same chroma
   u2r_pixel u_pixel_odd (
      .clock     (clock),
      .enable    (advance),
      .luma_term (s2_luma1_ff),
      .chroma    (s2_chroma_ff),
      .pixel     (pixel1)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef ASSERT_OFF
   // an accepted word lands in stage 1
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted word missing from stage 1");

   // a taken output word with nothing behind it leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (!rsp_stall && !s3_valid_ff) |=> !rsp_valid)
      else $error("output word repeated");

   // a held output word blocks the input side
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while output held");

   // reset empties the pipeline
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !s1_valid_ff && !s2_valid_ff && !s3_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

[hw/rtl/u2r_pixel.sv]
`default_nettype none

module u2r_pixel (
   input  wire logic                       clock,
   input  wire logic                       enable,
   input  wire logic [15:0]                luma_term,
   input  wire u2r_pkg::chroma_terms_type  chroma,
   output logic      [15:0]                pixel
);
   import u2r_pkg::*;

   logic signed [SUM_W-1:0] luma_s;
   logic signed [SUM_W-1:0] red_in,   green_in,   blue_in;
   logic signed [SUM_W-1:0] red_ff,   green_ff,   blue_ff;

   // channel sums before scaling
   always_comb begin
      luma_s   = signed'({2'b00, luma_term});
      red_in   = luma_s - R_BIAS + signed'({2'b00, chroma.red_v});
      green_in = luma_s + G_BIAS - signed'({2'b00, chroma.green_uv});
      blue_in  = luma_s - B_BIAS + signed'({2'b00, chroma.blue_u});
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   // scale, saturate and pack
   assign pixel = pack565(sat8(red_ff), sat8(green_ff), sat8(blue_ff));

endmodule

`default_nettype wire
